// ===== hdl/pbrp_pkg.sv =====
`default_nettype none

package pbrp_pkg;

    // Fixed field widths
    localparam int REQ_W   = 16;
    localparam int QUO_W   = 15;   // scaled speed never exceeds the positive request
    localparam int TIME_W  = 63;
    localparam int COUNT_W = 16;

    // Q8.8 speed format
    localparam int SPEED_FRAC_BITS = 8;
    localparam logic [REQ_W-1:0] UNIT_SPEED =
        (SPEED_FRAC_BITS >= 15) ? REQ_W'(32767) : REQ_W'(1 << SPEED_FRAC_BITS);
    // |delta| * 100 >= 2^frac  <=>  |delta| >= ceil(2^frac / 100)
    localparam int SPEED_THRESH = ((1 << SPEED_FRAC_BITS) + 99) / 100;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // Playback controller modes, as reported on the result channel
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PREROLL = 2'd1,
        MODE_RUNNING = 2'd2,
        MODE_REBUF   = 2'd3
    } mode_t;

    // Item class decided by the front
    typedef enum logic [1:0] {
        KIND_STOP,
        KIND_PREROLL,
        KIND_ACTIVE
    } kind_t;

    // Back sequencer states
    typedef enum logic [1:0] {
        ST_WAIT,
        ST_DIV,
        ST_EXEC
    } bstate_t;

    // Classified item as queued toward the back
    typedef struct packed {
        kind_t              kind;
        logic               held;
        logic               ready;
        logic               starve;
        logic               eof;
        logic               scale;
        logic [REQ_W-1:0]   req;
        logic [TIME_W-1:0]  now;
    } cmd_t;

    // Per-tick event flags of one result
    typedef struct packed {
        logic speed_changed;
        logic request_hold;
        logic release_hold;
        logic decode_restart;
        logic run_resumed;
        logic preroll_entry;
        logic entered_rebuffer;
    } evt_t;

endpackage

`default_nettype wire

// ===== hdl/pbrp_fifo.sv =====
`default_nettype none

module pbrp_fifo
    import pbrp_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty,
    output logic                  full
);

    logic [WIDTH-1:0]  mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign rdata = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) !(push && full))
        else $error("queue written while full");
    assert property (@(posedge aclk) disable iff (!aresetn) !(pop && empty))
        else $error("queue read while empty");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> !empty)
        else $error("queue lost a transfer");

endmodule

`default_nettype wire

// ===== hdl/pbrp_div.sv =====
`default_nettype none

module pbrp_div
    import pbrp_pkg::*;
#(
    parameter int DEN_W = 10,
    localparam int NUM_W = QUO_W + DEN_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic      [QUO_W-1:0] quo
);

    localparam int CNT_W = $clog2(QUO_W);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign busy = busy_reg;
    assign quo  = quo_reg;

    // One restoring step per cycle; the quotient is known to fit QUO_W bits,
    // so the upper part of the numerator already sits below the divisor
    always_comb begin
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        fits      = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = num[NUM_W-1:QUO_W];
            quo_next  = num[QUO_W-1:0];
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

endmodule

`default_nettype wire

// ===== hdl/pbrp_front.sv =====
`default_nettype none

module pbrp_front
    import pbrp_pkg::*;
#(
    parameter int FRAME_BITS = 8,
    localparam int DEN_W = FRAME_BITS + 2,
    localparam int NUM_W = QUO_W + DEN_W
) (
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [REQ_W-1:0]      s_requested_speed,
    input  wire logic                  s_is_playing,
    input  wire logic                  s_hold_active,
    input  wire logic                  s_tracks_active,
    input  wire logic                  s_preroll_blocked,
    input  wire logic                  s_resume_ready,
    input  wire logic                  s_starvation_risk,
    input  wire logic                  s_all_tracks_eof,
    input  wire logic                  s_frontier_limited,
    input  wire logic [FRAME_BITS-1:0] s_buffered_frames,
    input  wire logic [FRAME_BITS-1:0] s_target_frames,
    input  wire logic [TIME_W-1:0]     s_now_us,
    input  wire logic                  adaptive_enable,
    input  wire logic                  q_full,
    output logic                       q_push,
    output cmd_t                       cmd,
    output logic      [NUM_W-1:0]      num,
    output logic      [DEN_W-1:0]      den
);

    kind_t                 kind;
    logic [FRAME_BITS-1:0] buf_m1;
    logic [FRAME_BITS-1:0] ta;
    logic [FRAME_BITS-1:0] ba;
    logic [DEN_W-1:0]      fill_sum;
    logic                  req_pos;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Classify by the playback flags alone; mode-dependent choices are the back's
    always_comb begin
        priority if (!s_is_playing || !s_tracks_active) begin
            kind = KIND_STOP;
        end else if (s_preroll_blocked) begin
            kind = KIND_PREROLL;
        end else begin
            kind = KIND_ACTIVE;
        end
    end

    // Fill terms: buffered-1 clamped to target-1, numerator req*(ta + 3*ba)
    always_comb begin
        buf_m1   = (s_buffered_frames != '0) ? s_buffered_frames - 1'b1 : '0;
        ta       = s_target_frames - 1'b1;
        ba       = (buf_m1 > ta) ? ta : buf_m1;
        fill_sum = {2'b00, ta} + {2'b00, ba} + {1'b0, ba, 1'b0};
        req_pos  = !s_requested_speed[REQ_W-1] && (s_requested_speed != '0);
        num      = {{DEN_W{1'b0}}, s_requested_speed[QUO_W-1:0]}
                 * {{QUO_W{1'b0}}, fill_sum};
        den      = {ta, 2'b00};
    end

    // Queue entry
    always_comb begin
        cmd.kind   = kind;
        cmd.held   = s_hold_active;
        cmd.ready  = s_resume_ready;
        cmd.starve = s_starvation_risk;
        cmd.eof    = s_all_tracks_eof;
        cmd.scale  = (kind == KIND_ACTIVE) && adaptive_enable && s_frontier_limited
                   && req_pos && (s_target_frames > FRAME_BITS'(1));
        cmd.req    = s_requested_speed;
        cmd.now    = s_now_us;
    end

endmodule

`default_nettype wire

// ===== hdl/pbrp_back.sv =====
`default_nettype none

module pbrp_back
    import pbrp_pkg::*;
#(
    parameter int FRAME_BITS = 8,
    localparam int DEN_W = FRAME_BITS + 2,
    localparam int NUM_W = QUO_W + DEN_W
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_empty,
    output logic                    q_pop,
    input  wire cmd_t               cmd,
    input  wire logic [NUM_W-1:0]   num,
    input  wire logic [DEN_W-1:0]   den,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [1:0]         m_mode,
    output logic      [REQ_W-1:0]   m_effective_speed,
    output evt_t                    m_evt,
    output logic      [COUNT_W-1:0] m_rebuffer_events,
    output logic      [TIME_W-1:0]  m_rebuffer_time_us
);

    bstate_t              state_reg, state_next;
    cmd_t                 work_reg, work_next;
    logic [TIME_W:0]      diff_reg, diff_next;
    mode_t                mode_reg, mode_next;
    logic [REQ_W-1:0]     speed_reg, speed_next;
    logic [TIME_W-1:0]    start_reg, start_next;
    logic [TIME_W-1:0]    total_reg, total_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    evt_t                 evt_reg, evt_next;
    logic                 m_valid_reg, m_valid_next;

    logic                 out_free;
    logic                 exec_fire;
    logic                 div_start;
    logic                 div_busy;
    logic [QUO_W-1:0]     div_quo;

    // Per-tick decision terms
    mode_t                mode_mid;
    logic [REQ_W-1:0]     pick;
    logic [REQ_W-1:0]     cand;
    logic                 do_apply;
    logic [REQ_W:0]       delta;
    logic [REQ_W:0]       delta_abs;
    logic [TIME_W:0]      time_sum;
    evt_t                 evt;
    mode_t                mode_t_n;
    logic [TIME_W-1:0]    start_t_n;
    logic [TIME_W-1:0]    total_t_n;
    logic [COUNT_W-1:0]   count_t_n;

    pbrp_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num),
        .den     (den),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign exec_fire = (state_reg == ST_EXEC) && out_free;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_WAIT: begin
                if (!q_empty) begin
                    state_next = cmd.scale ? ST_DIV : ST_EXEC;
                end
            end
            ST_DIV: begin
                if (!div_busy) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_WAIT;
                end
            end
            default: state_next = ST_WAIT;
        endcase
    end

    // Controller decision for the held item
    always_comb begin
        evt       = '0;
        mode_t_n  = mode_reg;
        start_t_n = start_reg;
        total_t_n = total_reg;
        count_t_n = count_reg;
        do_apply  = 1'b0;
        pick      = work_reg.scale ? {1'b0, div_quo}
                  : (work_reg.req[REQ_W-1] ? '0 : work_reg.req);
        cand      = pick;
        mode_mid  = (mode_reg == MODE_IDLE && work_reg.held) ? MODE_REBUF : mode_reg;
        time_sum  = {1'b0, total_reg} + {1'b0, diff_reg[TIME_W-1:0]};
        unique case (work_reg.kind)
            KIND_STOP: begin
                if (!work_reg.held) begin
                    mode_t_n = MODE_IDLE;
                end
                cand     = work_reg.req;
                do_apply = 1'b1;
            end
            KIND_PREROLL: begin
                evt.preroll_entry = (mode_reg != MODE_PREROLL);
                evt.request_hold  = !work_reg.held;
                mode_t_n          = MODE_PREROLL;
            end
            default: begin
                if (mode_mid == MODE_PREROLL || mode_mid == MODE_REBUF) begin
                    mode_t_n = mode_mid;
                    if (!work_reg.ready) begin
                        evt.request_hold = !work_reg.held;
                    end else begin
                        do_apply           = 1'b1;
                        evt.release_hold   = work_reg.held;
                        evt.decode_restart = 1'b1;
                        evt.run_resumed    = 1'b1;
                        mode_t_n           = MODE_RUNNING;
                        // diff_reg carries a borrow when the clock went backwards
                        if (mode_mid == MODE_REBUF && start_reg != '0
                                && !diff_reg[TIME_W]) begin
                            total_t_n = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
                        end
                        start_t_n = '0;
                    end
                end else if (work_reg.starve && !work_reg.eof) begin
                    mode_t_n             = MODE_REBUF;
                    evt.entered_rebuffer = 1'b1;
                    evt.request_hold     = !work_reg.held;
                    if (count_reg != '1) begin
                        count_t_n = count_reg + 1'b1;
                    end
                    start_t_n = work_reg.now;
                end else begin
                    mode_t_n = MODE_RUNNING;
                    do_apply = 1'b1;
                end
            end
        endcase
        // Speed moves only on a large enough step
        delta     = {cand[REQ_W-1], cand} - {speed_reg[REQ_W-1], speed_reg};
        delta_abs = delta[REQ_W] ? (~delta + 1'b1) : delta;
        evt.speed_changed = do_apply && (delta_abs >= (REQ_W+1)'(SPEED_THRESH));
    end

    // Register updates and handshake outputs
    always_comb begin
        q_pop        = (state_reg == ST_WAIT) && !q_empty;
        div_start    = q_pop && cmd.scale;
        work_next    = q_pop ? cmd : work_reg;
        diff_next    = q_pop ? ({1'b0, cmd.now} - {1'b0, start_reg}) : diff_reg;
        mode_next    = mode_reg;
        speed_next   = speed_reg;
        start_next   = start_reg;
        total_next   = total_reg;
        count_next   = count_reg;
        evt_next     = evt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (exec_fire) begin
            mode_next    = mode_t_n;
            speed_next   = evt.speed_changed ? cand : speed_reg;
            start_next   = start_t_n;
            total_next   = total_t_n;
            count_next   = count_t_n;
            evt_next     = evt;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_WAIT;
            mode_reg    <= MODE_IDLE;
            speed_reg   <= UNIT_SPEED;
            start_reg   <= '0;
            total_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            speed_reg   <= speed_next;
            start_reg   <= start_next;
            total_reg   <= total_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        diff_reg <= diff_next;
        evt_reg  <= evt_next;
    end

    // State registers only change when the previous result leaves, so they
    // double as the result payload
    assign m_valid            = m_valid_reg;
    assign m_mode             = mode_reg;
    assign m_effective_speed  = speed_reg;
    assign m_evt              = evt_reg;
    assign m_rebuffer_events  = count_reg;
    assign m_rebuffer_time_us = total_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (count_reg >= $past(count_reg)))
        else $error("rebuffer event count went down");
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (total_reg >= $past(total_reg)))
        else $error("rebuffer time went down");
    assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire |=> m_valid_reg)
        else $error("executed item produced no result");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && evt_reg.entered_rebuffer) |-> (mode_reg == MODE_REBUF))
        else $error("rebuffer entry reported outside rebuffering");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> work_reg.scale)
        else $error("divider run for an unscaled item");

endmodule

`default_nettype wire

// ===== hdl/playback_rebuffer_pacing_fsm_core.sv =====
`default_nettype none

// Playback rebuffer pacing controller. Each transfer on the s_ channel is one
// evaluation tick; each yields exactly one result on the m_ channel carrying
// the mode after the tick (idle, preroll, running, rebuffering), the stored
// Q8.8 speed, the hold/resume event flags and the saturating rebuffer count
// and time. The front classifies a tick and forms the fill-scaled speed
// numerator; a two-entry queue feeds the back, which runs the controller.
// In the back a tick passes the wait and execute states, and the divide
// state too when adaptive pacing scales the speed with the 15-step restoring
// divider; the front keeps accepting while the queue has room and a finished
// result waits in the output stage. adaptive_enable resets to 1; the user must
// write it via cfg_wr_en/cfg_wr_data only while the block is idle (unchecked).
module playback_rebuffer_pacing_fsm_core
    import pbrp_pkg::*;
#(
    parameter int FRAME_BITS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [REQ_W-1:0]      s_requested_speed,
    input  wire logic                  s_is_playing,
    input  wire logic                  s_hold_active,
    input  wire logic                  s_tracks_active,
    input  wire logic                  s_preroll_blocked,
    input  wire logic                  s_resume_ready,
    input  wire logic                  s_starvation_risk,
    input  wire logic                  s_all_tracks_eof,
    input  wire logic                  s_frontier_limited,
    input  wire logic [FRAME_BITS-1:0] s_buffered_frames,
    input  wire logic [FRAME_BITS-1:0] s_target_frames,
    input  wire logic [TIME_W-1:0]     s_now_us,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [1:0]            m_mode,
    output logic      [REQ_W-1:0]      m_effective_speed,
    output logic                       m_speed_changed,
    output logic                       m_request_hold,
    output logic                       m_release_hold,
    output logic                       m_decode_restart,
    output logic                       m_run_resumed,
    output logic                       m_preroll_entry,
    output logic                       m_entered_rebuffer,
    output logic      [COUNT_W-1:0]    m_rebuffer_events,
    output logic      [TIME_W-1:0]     m_rebuffer_time_us
);

    localparam int DEN_W = FRAME_BITS + 2;
    localparam int NUM_W = QUO_W + DEN_W;
    localparam int Q_W   = $bits(cmd_t) + NUM_W + DEN_W;

    logic             adaptive_reg, adaptive_next;
    logic             q_push, q_pop, q_empty, q_full;
    cmd_t             f_cmd, b_cmd;
    logic [NUM_W-1:0] f_num, b_num;
    logic [DEN_W-1:0] f_den, b_den;
    logic [Q_W-1:0]   q_rdata;
    evt_t             evt;

    // Configuration register
    assign adaptive_next = cfg_wr_en ? cfg_wr_data : adaptive_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adaptive_reg <= 1'b1;
        end else begin
            adaptive_reg <= adaptive_next;
        end
    end

    // Front: accept and classify
    pbrp_front #(
        .FRAME_BITS (FRAME_BITS)
    ) u_front (
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_requested_speed  (s_requested_speed),
        .s_is_playing       (s_is_playing),
        .s_hold_active      (s_hold_active),
        .s_tracks_active    (s_tracks_active),
        .s_preroll_blocked  (s_preroll_blocked),
        .s_resume_ready     (s_resume_ready),
        .s_starvation_risk  (s_starvation_risk),
        .s_all_tracks_eof   (s_all_tracks_eof),
        .s_frontier_limited (s_frontier_limited),
        .s_buffered_frames  (s_buffered_frames),
        .s_target_frames    (s_target_frames),
        .s_now_us           (s_now_us),
        .adaptive_enable    (adaptive_reg),
        .q_full             (q_full),
        .q_push             (q_push),
        .cmd                (f_cmd),
        .num                (f_num),
        .den                (f_den)
    );

    // Queue between front and back
    pbrp_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   ({f_cmd, f_num, f_den}),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty),
        .full    (q_full)
    );

    assign {b_cmd, b_num, b_den} = q_rdata;

    // Back: controller, divider and result stage
    pbrp_back #(
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_empty            (q_empty),
        .q_pop              (q_pop),
        .cmd                (b_cmd),
        .num                (b_num),
        .den                (b_den),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_mode             (m_mode),
        .m_effective_speed  (m_effective_speed),
        .m_evt              (evt),
        .m_rebuffer_events  (m_rebuffer_events),
        .m_rebuffer_time_us (m_rebuffer_time_us)
    );

    assign m_speed_changed    = evt.speed_changed;
    assign m_request_hold     = evt.request_hold;
    assign m_release_hold     = evt.release_hold;
    assign m_decode_restart   = evt.decode_restart;
    assign m_run_resumed      = evt.run_resumed;
    assign m_preroll_entry    = evt.preroll_entry;
    assign m_entered_rebuffer = evt.entered_rebuffer;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none

module testbench
    import pbrp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_W = 8;
    localparam logic [TIME_W-1:0] TIME_SAT = '1;
    localparam int PHASE_ITEMS = 300;
    localparam int HOLD_OFF_AT = 350;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    // One evaluation tick as offered on the s_ channel
    typedef struct packed {
        logic signed [REQ_W-1:0] req;
        logic                    playing;
        logic                    held;
        logic                    tracks;
        logic                    pre_blk;
        logic                    ready;
        logic                    starve;
        logic                    eof;
        logic                    frontier;
        logic [FRAME_W-1:0]      buffered;
        logic [FRAME_W-1:0]      target;
        logic [TIME_W-1:0]       now;
    } tick_t;

    // One controller result as seen on the m_ channel
    typedef struct packed {
        mode_t                   mode;
        logic signed [REQ_W-1:0] speed;
        evt_t                    evt;
        logic [COUNT_W-1:0]      rb_events;
        logic [TIME_W-1:0]       rb_time;
    } result_t;

    // Pacing controller state tracker and result queue
    class pacing_scoreboard;
        mode_t                   mode;
        logic signed [REQ_W-1:0] speed;
        logic [TIME_W-1:0]       rb_start;
        logic [TIME_W-1:0]       rb_total;
        logic [COUNT_W-1:0]      rb_count;
        bit                      adaptive;
        result_t                 outcome_q[$];
        int                      errors;
        int                      checked;

        function new();
            int one;
            one = 1 << SPEED_FRAC_BITS;
            mode = MODE_IDLE;
            speed = REQ_W'((one > 32767) ? 32767 : one);
            rb_start = '0;
            rb_total = '0;
            rb_count = '0;
            adaptive = 1'b1;
            errors = 0;
            checked = 0;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        // Requested speed scaled by 0.25 + 0.75 * fill when pacing applies
        function int fill_scaled_speed(tick_t t);
            int                req;
            int unsigned       ahead;
            int unsigned       goal;
            longint unsigned   num;
            req = t.req;
            if (req <= 0 || !adaptive || !t.frontier || t.target <= 1)
                return (req > 0) ? req : 0;
            ahead = (t.buffered > 0) ? t.buffered - 1 : 0;
            goal = t.target - 1;
            if (ahead > goal)
                ahead = goal;
            num = longint'(req) * longint'(goal + 3 * ahead);
            return int'(num / (4 * goal));
        endfunction

        // Stored speed moves only on a step of at least 0.01
        function bit move_speed(int cand);
            int d;
            d = cand - int'(speed);
            if (d < 0)
                d = -d;
            if (d * 100 < (1 << SPEED_FRAC_BITS))
                return 1'b0;
            speed = REQ_W'(cand);
            return 1'b1;
        endfunction

        function void note_tick(tick_t t);
            result_t         r;
            bit              from_rebuf;
            logic [TIME_W:0] sum;
            r.evt = '0;
            if (!t.playing || !t.tracks) begin
                if (!t.held)
                    mode = MODE_IDLE;
                r.evt.speed_changed = move_speed(t.req);
            end else if (t.pre_blk) begin
                r.evt.preroll_entry = (mode != MODE_PREROLL);
                mode = MODE_PREROLL;
                r.evt.request_hold = !t.held;
            end else begin
                // hold already in place while idle counts as rebuffering
                if (mode == MODE_IDLE && t.held)
                    mode = MODE_REBUF;
                if (mode == MODE_PREROLL || mode == MODE_REBUF) begin
                    if (!t.ready) begin
                        r.evt.request_hold = !t.held;
                    end else begin
                        from_rebuf = (mode == MODE_REBUF);
                        r.evt.speed_changed = move_speed(fill_scaled_speed(t));
                        r.evt.release_hold = t.held;
                        r.evt.decode_restart = 1'b1;
                        r.evt.run_resumed = 1'b1;
                        mode = MODE_RUNNING;
                        // no start recorded or clock went back: nothing added
                        if (from_rebuf && rb_start != 0 && t.now >= rb_start) begin
                            sum = (TIME_W + 1)'(rb_total) + (TIME_W + 1)'(t.now - rb_start);
                            rb_total = (sum > TIME_SAT) ? TIME_SAT : sum[TIME_W-1:0];
                        end
                        rb_start = '0;
                    end
                end else if (t.starve && !t.eof) begin
                    mode = MODE_REBUF;
                    r.evt.entered_rebuffer = 1'b1;
                    r.evt.request_hold = !t.held;
                    if (rb_count != '1)
                        rb_count++;
                    rb_start = t.now;
                end else begin
                    mode = MODE_RUNNING;
                    r.evt.speed_changed = move_speed(fill_scaled_speed(t));
                end
            end
            r.mode = mode;
            r.speed = speed;
            r.rb_events = rb_count;
            r.rb_time = rb_total;
            outcome_q.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            checked++;
            if (outcome_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result %0d: no result expected", checked);
                return;
            end
            want = outcome_q.pop_front();
            if (got.mode !== want.mode || got.speed !== want.speed ||
                got.evt !== want.evt || got.rb_events !== want.rb_events ||
                got.rb_time !== want.rb_time) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("result %0d: want mode=%0d speed=%0d flags=%b ev=%0d us=%0d",
                             checked, want.mode, want.speed, want.evt, want.rb_events,
                             want.rb_time);
                    $display("result %0d: got  mode=%0d speed=%0d flags=%b ev=%0d us=%0d",
                             checked, got.mode, got.speed, got.evt, got.rb_events,
                             got.rb_time);
                end
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [REQ_W-1:0]     s_requested_speed = '0;
    logic                 s_is_playing = 1'b0;
    logic                 s_hold_active = 1'b0;
    logic                 s_tracks_active = 1'b0;
    logic                 s_preroll_blocked = 1'b0;
    logic                 s_resume_ready = 1'b0;
    logic                 s_starvation_risk = 1'b0;
    logic                 s_all_tracks_eof = 1'b0;
    logic                 s_frontier_limited = 1'b0;
    logic [FRAME_W-1:0]   s_buffered_frames = '0;
    logic [FRAME_W-1:0]   s_target_frames = '0;
    logic [TIME_W-1:0]    s_now_us = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [1:0]           m_mode;
    logic [REQ_W-1:0]     m_effective_speed;
    logic                 m_speed_changed;
    logic                 m_request_hold;
    logic                 m_release_hold;
    logic                 m_decode_restart;
    logic                 m_run_resumed;
    logic                 m_preroll_entry;
    logic                 m_entered_rebuffer;
    logic [COUNT_W-1:0]   m_rebuffer_events;
    logic [TIME_W-1:0]    m_rebuffer_time_us;

    pacing_scoreboard sb = new();
    logic [TIME_W-1:0] now_cursor = '0;
    int burst_left = 0;

    playback_rebuffer_pacing_fsm_core #(
        .FRAME_BITS(FRAME_W)
    ) DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_requested_speed  (s_requested_speed),
        .s_is_playing       (s_is_playing),
        .s_hold_active      (s_hold_active),
        .s_tracks_active    (s_tracks_active),
        .s_preroll_blocked  (s_preroll_blocked),
        .s_resume_ready     (s_resume_ready),
        .s_starvation_risk  (s_starvation_risk),
        .s_all_tracks_eof   (s_all_tracks_eof),
        .s_frontier_limited (s_frontier_limited),
        .s_buffered_frames  (s_buffered_frames),
        .s_target_frames    (s_target_frames),
        .s_now_us           (s_now_us),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_mode             (m_mode),
        .m_effective_speed  (m_effective_speed),
        .m_speed_changed    (m_speed_changed),
        .m_request_hold     (m_request_hold),
        .m_release_hold     (m_release_hold),
        .m_decode_restart   (m_decode_restart),
        .m_run_resumed      (m_run_resumed),
        .m_preroll_entry    (m_preroll_entry),
        .m_entered_rebuffer (m_entered_rebuffer),
        .m_rebuffer_events  (m_rebuffer_events),
        .m_rebuffer_time_us (m_rebuffer_time_us)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("playback_rebuffer_pacing_fsm_core: mismatch");
        $finish;
    end

    // Offer one tick, hold it until transfer, then maybe open a gap
    task automatic drive_tick(tick_t t);
        int gap;
        s_valid <= 1'b1;
        s_requested_speed <= t.req;
        s_is_playing <= t.playing;
        s_hold_active <= t.held;
        s_tracks_active <= t.tracks;
        s_preroll_blocked <= t.pre_blk;
        s_resume_ready <= t.ready;
        s_starvation_risk <= t.starve;
        s_all_tracks_eof <= t.eof;
        s_frontier_limited <= t.frontier;
        s_buffered_frames <= t.buffered;
        s_target_frames <= t.target;
        s_now_us <= t.now;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(t);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    // Drain every outstanding result, then let the back settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_adaptive(bit value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.adaptive = value;
    endtask

    function automatic tick_t quiet_tick();
        tick_t t;
        t = '0;
        t.req = 16'sd256;
        t.playing = 1'b1;
        t.tracks = 1'b1;
        return t;
    endfunction

    function automatic logic [FRAME_W-1:0] random_frames();
        if ($urandom_range(0, 3) == 0)
            return FRAME_W'($urandom_range(0, 3));
        return FRAME_W'($urandom);
    endfunction

    // Mostly live playback with random flags; time mostly moves forward
    function automatic tick_t random_tick();
        tick_t t;
        case ($urandom_range(0, 9))
            0: t.req = REQ_W'($urandom);
            1: begin
                case ($urandom_range(0, 4))
                    0: t.req = 16'sh8000;
                    1: t.req = 16'sh7fff;
                    2: t.req = 16'sd0;
                    3: t.req = -16'sd1;
                    default: t.req = 16'sd1;
                endcase
            end
            2: t.req = REQ_W'($urandom_range(0, 32767)) | 16'sh8000;
            3, 4, 5: t.req = REQ_W'(250 + $urandom_range(0, 12));
            default: t.req = REQ_W'($urandom_range(0, 1024));
        endcase
        t.playing = ($urandom_range(0, 9) != 0);
        t.tracks = ($urandom_range(0, 9) != 0);
        t.held = 1'($urandom_range(0, 1));
        t.pre_blk = ($urandom_range(0, 6) == 0);
        t.ready = 1'($urandom_range(0, 1));
        t.starve = ($urandom_range(0, 3) == 0);
        t.eof = ($urandom_range(0, 4) == 0);
        t.frontier = ($urandom_range(0, 2) != 0);
        t.buffered = random_frames();
        t.target = random_frames();
        case ($urandom_range(0, 39))
            0: now_cursor = TIME_W'({$urandom, $urandom});
            1: now_cursor = now_cursor - TIME_W'($urandom_range(0, 5000));
            2: now_cursor = TIME_SAT - TIME_W'($urandom_range(0, 1000));
            3: now_cursor = '0;
            default: now_cursor = now_cursor + TIME_W'($urandom_range(1, 200000));
        endcase
        t.now = now_cursor;
        return t;
    endfunction

    // Walk the controller through each state and corner
    task automatic directed_ticks();
        tick_t t;
        // stopped: equal speed, then both speed extremes, hold keeps mode
        t = quiet_tick(); t.playing = 1'b0; drive_tick(t);
        t.held = 1'b1; t.req = 16'sh8000; drive_tick(t);
        t.tracks = 1'b0; t.req = 16'sh7fff; drive_tick(t);
        // preroll entry, then repeat while held
        t = quiet_tick(); t.pre_blk = 1'b1; drive_tick(t);
        t.held = 1'b1; drive_tick(t);
        // preroll not ready, then resume with full buffer
        t = quiet_tick(); drive_tick(t);
        t = quiet_tick(); t.ready = 1'b1; t.held = 1'b1; t.frontier = 1'b1;
        t.buffered = 8'd255; t.target = 8'd255; drive_tick(t);
        // running: starvation at end of stream stays running, empty buffer
        t = quiet_tick(); t.starve = 1'b1; t.eof = 1'b1; t.frontier = 1'b1;
        t.req = 16'sd1000; t.target = 8'd2; drive_tick(t);
        // rebuffer at time zero, resume adds nothing
        t = quiet_tick(); t.starve = 1'b1; drive_tick(t);
        t = quiet_tick(); t.ready = 1'b1; t.now = 63'd5000; drive_tick(t);
        // rebuffer spanning the whole time range, then saturate the total
        t = quiet_tick(); t.starve = 1'b1; t.now = 63'd1; drive_tick(t);
        t = quiet_tick(); t.ready = 1'b1; t.req = -16'sd5; t.target = 8'd1;
        t.now = TIME_SAT; drive_tick(t);
        t = quiet_tick(); t.starve = 1'b1; t.held = 1'b1; t.now = 63'd1; drive_tick(t);
        t = quiet_tick(); t.ready = 1'b1; t.now = 63'd3; drive_tick(t);
        // clock runs backwards across a rebuffer
        t = quiet_tick(); t.starve = 1'b1; t.now = 63'd1000; drive_tick(t);
        t = quiet_tick(); t.ready = 1'b1; t.now = 63'd500; drive_tick(t);
        // back to idle, then idle with a hold already in force
        t = quiet_tick(); t.playing = 1'b0; drive_tick(t);
        t = quiet_tick(); t.held = 1'b1; drive_tick(t);
        t = quiet_tick(); t.held = 1'b1; t.ready = 1'b1; t.now = 63'd9000; drive_tick(t);
        // speed step just under and just at the threshold
        t = quiet_tick(); t.playing = 1'b0; t.held = 1'b1; t.req = sb.speed + 16'sd2;
        drive_tick(t);
        t.req = sb.speed + 16'sd3; drive_tick(t);
        // running with scaling off by target, then clamped fill, then partial fill
        t = quiet_tick(); t.frontier = 1'b1; t.req = 16'sd700; drive_tick(t);
        t = quiet_tick(); t.frontier = 1'b1; t.req = 16'sh7fff;
        t.buffered = 8'd200; t.target = 8'd10; drive_tick(t);
        t = quiet_tick(); t.frontier = 1'b1; t.req = 16'sh7fff;
        t.buffered = 8'd3; t.target = 8'd9; drive_tick(t);
    endtask

    // Result side: check each transfer and stall on a pattern of its own
    initial begin
        result_t got;
        int stretch;
        int style;
        int hold_left;
        bit pressed;
        stretch = 0;
        style = 0;
        hold_left = 0;
        pressed = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.mode = mode_t'(m_mode);
                got.speed = m_effective_speed;
                got.evt = {m_speed_changed, m_request_hold, m_release_hold,
                           m_decode_restart, m_run_resumed, m_preroll_entry,
                           m_entered_rebuffer};
                got.rb_events = m_rebuffer_events;
                got.rb_time = m_rebuffer_time_us;
                sb.check_result(got);
            end
            // one long hold-off so the block backs up into its input
            if (!pressed && sb.checked >= HOLD_OFF_AT) begin
                pressed = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (stretch == 0) begin
                style = $urandom_range(0, 3);
                stretch = $urandom_range(20, 200);
            end
            stretch--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (style)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Stimulus: reset, directed ticks, then random phases per pacing setting
    initial begin
        bit phase_cfg[4];
        phase_cfg = '{1'b0, 1'b1, 1'b0, 1'b1};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_adaptive(1'b1);
        directed_ticks();
        foreach (phase_cfg[p]) begin
            wait_idle();
            write_adaptive(phase_cfg[p]);
            repeat (PHASE_ITEMS) drive_tick(random_tick());
        end
        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("playback_rebuffer_pacing_fsm_core: match");
        end else begin
            $display("playback_rebuffer_pacing_fsm_core: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
